@@ rtl/core/midi_pkg.sv @@
package midi_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_PERIOD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_PERIODS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_TIME = 3'd4;

  localparam logic [22:0] RST_AMPLITUDE = 23'd12800;
  localparam logic [31:0] RST_PHASE_STEP = 32'd53972316;
  localparam logic [23:0] RST_SAMPLES_PER_PERIOD = 24'd80;
  localparam logic [7:0] RST_NUM_PERIODS = 8'd10;
  localparam logic [31:0] RST_SAMPLE_TIME = 32'd4294967;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
  localparam logic [31:0] RPM_TO_RAD_Q16 = 32'd1756906;
  localparam logic [8:0] PERIOD_MAX = 9'd256;

  typedef struct packed {
    logic func;
    logic signed [31:0] speed;
    logic signed [31:0] torque;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] speed_ref_rpm;
    logic signed [31:0] speed_ref_rad;
    logic signed [31:0] damping_est;
    logic signed [31:0] inertia_est;
    logic signed [31:0] damping_held;
    logic signed [31:0] inertia_held;
    logic [8:0] period_index;
    logic finished;
    logic divide_invalid;
  } out_item_t;

endpackage

@@ rtl/core/motor_inertia_damping_identifier_core.sv @@
// Channel   Direction  Handshake           Payload
// in        input      in_valid/in_stall   midi_pkg::in_item_t
// out       output     out_valid/out_stall midi_pkg::out_item_t
// cfg       input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// A clear item goes from the idle state straight to the output state and its result register.
// A step item runs nine products on the shared 64 by 32 shift-add multiplier, then up
// to two quotients on the restoring divider, then updates the period counters in the
// final state. The input is stalled while an item is at work; a result waiting on
// out_stall holds the next item only in its output state. rst is synchronous and
// restores the configuration and the run state: counters, phase, integrals, estimates
// and the finished flag.
module motor_inertia_damping_identifier_core #(
  parameter int SINE_TABLE_DEPTH = 256,
  parameter int ACC_WIDTH = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  midi_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output midi_pkg::out_item_t out_data,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [midi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [midi_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
  localparam logic [63:0] ACC_MAX = (64'd1 << (ACC_WIDTH - 1)) - 64'd1;
  localparam logic signed [65:0] ACC_MAX_S = (66'sd1 <<< (ACC_WIDTH - 1)) - 66'sd1;
  localparam logic signed [65:0] ACC_MIN_S = -ACC_MAX_S - 66'sd1;

  typedef logic signed [15:0] sine_tab_t [SINE_TABLE_DEPTH];

  function automatic sine_tab_t build_sine();
    sine_tab_t tab;
    logic [63:0] f, w, x, x2, t, s, v;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      f = (64'(k) << (32 - IDX_W)) & 64'hFFFF_FFFF;
      w = {34'd0, f[29:0]};
      if (f[30]) w = midi_pkg::ONE_Q30 - w;
      x = (w * midi_pkg::HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      t = midi_pkg::ONE_Q30 - x2 / 72;
      t = midi_pkg::ONE_Q30 - ((x2 * t) >> 30) / 42;
      t = midi_pkg::ONE_Q30 - ((x2 * t) >> 30) / 20;
      t = midi_pkg::ONE_Q30 - ((x2 * t) >> 30) / 6;
      s = (x * t) >> 30;
      v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) v = 64'd32767;
      tab[k] = f[31] ? -16'(v) : 16'(v);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_ROM = build_sine();

  function automatic logic [ACC_WIDTH-1:0] sat_add(input logic [ACC_WIDTH-1:0] a,
                                                   input logic [63:0] mag,
                                                   input logic neg);
    logic signed [65:0] term;
    logic signed [65:0] sum;
    term = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    sum = $signed({{(66 - ACC_WIDTH){a[ACC_WIDTH-1]}}, a}) + term;
    if (sum > ACC_MAX_S) return ACC_MAX_S[ACC_WIDTH-1:0];
    if (sum < ACC_MIN_S) return ACC_MIN_S[ACC_WIDTH-1:0];
    return sum[ACC_WIDTH-1:0];
  endfunction

  function automatic logic [63:0] clamp_shift(input logic [95:0] p, input int sh);
    logic [95:0] r;
    r = p >> sh;
    return (r > {32'd0, ACC_MAX}) ? ACC_MAX : r[63:0];
  endfunction

  function automatic logic [63:0] acc_ext(input logic [ACC_WIDTH-1:0] a);
    return {{(64 - ACC_WIDTH){a[ACC_WIDTH-1]}}, a};
  endfunction

  typedef enum logic [3:0] {
    ST_IDLE, ST_MSTART, ST_MRUN, ST_MDONE, ST_DSTART, ST_DRUN, ST_DDONE, ST_FINAL, ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_WT, OP_WT_TS, OP_WW, OP_WW_TS, OP_T_TS, OP_TI_W, OP_TIW_TS, OP_RPM, OP_RAD
  } op_t;

  state_t state;
  op_t op;

  logic [22:0] amplitude;
  logic [31:0] phase_step;
  logic [23:0] samples_per_period;
  logic [7:0] num_periods;
  logic [31:0] sample_time;

  logic [31:0] sample_count;
  logic [31:0] phase_acc;
  logic [8:0] period_counter;
  logic [ACC_WIDTH-1:0] power_integral;
  logic [ACC_WIDTH-1:0] speed_sq_integral;
  logic [ACC_WIDTH-1:0] torque_integral;
  logic [ACC_WIDTH-1:0] torque_int_speed_sum;
  logic signed [31:0] held_damping;
  logic signed [31:0] held_inertia;
  logic signed [31:0] cur_damping;
  logic signed [31:0] cur_inertia;
  logic done_flag;
  logic invalid;

  logic [31:0] w_mag;
  logic [31:0] t_mag;
  logic w_neg;
  logic t_neg;
  logic signed [15:0] sine_val;
  logic [63:0] pr;
  logic [23:0] rpm_mag;
  logic [31:0] rad_mag;

  logic [63:0] mult_a;
  logic [63:0] hi;
  logic [31:0] lo;
  logic [4:0] cnt;

  logic div_sel;
  logic div_neg;
  logic div_sat;
  logic [63:0] rem;
  logic [30:0] nb;
  logic [30:0] quo;

  logic [31:0] phase_next;
  logic [63:0] op_a;
  logic [31:0] op_b;
  logic [64:0] mul_sum;
  logic [95:0] prod;
  logic [63:0] ti_ext;
  logic [63:0] ti_mag;
  logic [63:0] num_ext;
  logic [63:0] num_mag;
  logic [63:0] den;
  logic [64:0] rem_shift;
  logic div_bit;
  logic signed [31:0] div_res;
  logic [32:0] period_limit;
  logic [31:0] finish_limit;
  logic [14:0] sine_mag;

  assign in_stall = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  assign phase_next = phase_acc + phase_step;
  assign sine_mag = sine_val[15] ? 15'(-sine_val) : sine_val[14:0];
  assign ti_ext = acc_ext(torque_integral);
  assign ti_mag = ti_ext[63] ? -ti_ext : ti_ext;
  assign mul_sum = {1'b0, hi} + (lo[0] ? {1'b0, mult_a} : 65'd0);
  assign prod = {hi, lo};
  assign num_ext = div_sel ? acc_ext(torque_int_speed_sum) : acc_ext(power_integral);
  assign num_mag = num_ext[63] ? -num_ext : num_ext;
  assign den = acc_ext(speed_sq_integral);
  assign rem_shift = {rem, nb[30]};
  assign div_bit = (rem_shift >= {1'b0, den});
  assign div_res = div_sat ? (div_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                           : (div_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo}));
  assign period_limit = {9'd0, samples_per_period} * {24'd0, period_counter};
  assign finish_limit = {24'd0, num_periods} * {8'd0, samples_per_period};

  always_comb begin
    op_a = pr;
    op_b = sample_time;
    case (op)
      OP_WT: begin
        op_a = {32'd0, w_mag};
        op_b = t_mag;
      end
      OP_WW: begin
        op_a = {32'd0, w_mag};
        op_b = w_mag;
      end
      OP_T_TS: op_a = {32'd0, t_mag};
      OP_TI_W: begin
        op_a = ti_mag;
        op_b = w_mag;
      end
      OP_RPM: begin
        op_a = {41'd0, amplitude};
        op_b = {17'd0, sine_mag};
      end
      OP_RAD: begin
        op_a = {40'd0, rpm_mag};
        op_b = midi_pkg::RPM_TO_RAD_Q16;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op <= OP_WT;
      amplitude <= midi_pkg::RST_AMPLITUDE;
      phase_step <= midi_pkg::RST_PHASE_STEP;
      samples_per_period <= midi_pkg::RST_SAMPLES_PER_PERIOD;
      num_periods <= midi_pkg::RST_NUM_PERIODS;
      sample_time <= midi_pkg::RST_SAMPLE_TIME;
      sample_count <= '0;
      phase_acc <= '0;
      period_counter <= 9'd1;
      power_integral <= '0;
      speed_sq_integral <= '0;
      torque_integral <= '0;
      torque_int_speed_sum <= '0;
      held_damping <= '0;
      held_inertia <= '0;
      cur_damping <= '0;
      cur_inertia <= '0;
      done_flag <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          midi_pkg::CFG_AMPLITUDE: amplitude <= cfg_data[22:0];
          midi_pkg::CFG_PHASE_STEP: phase_step <= cfg_data;
          midi_pkg::CFG_SAMPLES_PER_PERIOD: samples_per_period <= cfg_data[23:0];
          midi_pkg::CFG_NUM_PERIODS: num_periods <= cfg_data[7:0];
          midi_pkg::CFG_SAMPLE_TIME: sample_time <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall && state != ST_OUT) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (!in_data.func) begin
              sample_count <= '0;
              phase_acc <= '0;
              period_counter <= 9'd1;
              power_integral <= '0;
              speed_sq_integral <= '0;
              torque_integral <= '0;
              torque_int_speed_sum <= '0;
              done_flag <= 1'b0;
              cur_damping <= '0;
              cur_inertia <= '0;
              rpm_mag <= '0;
              rad_mag <= '0;
              invalid <= 1'b1;
              state <= ST_OUT;
            end else begin
              if (sample_count != 32'hFFFF_FFFF) sample_count <= sample_count + 32'd1;
              phase_acc <= phase_next;
              sine_val <= SINE_ROM[phase_next[31 -: IDX_W]];
              w_neg <= in_data.speed[31];
              t_neg <= in_data.torque[31];
              w_mag <= in_data.speed[31] ? 32'(-in_data.speed) : in_data.speed;
              t_mag <= in_data.torque[31] ? 32'(-in_data.torque) : in_data.torque;
              op <= OP_WT;
              state <= ST_MSTART;
            end
          end
        end
        ST_MSTART: begin
          mult_a <= op_a;
          hi <= '0;
          lo <= op_b;
          cnt <= '0;
          state <= ST_MRUN;
        end
        ST_MRUN: begin
          hi <= mul_sum[64:1];
          lo <= {mul_sum[0], lo[31:1]};
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) state <= ST_MDONE;
        end
        ST_MDONE: begin
          state <= ST_MSTART;
          case (op)
            OP_WT: begin
              pr <= prod[63:0];
              op <= OP_WT_TS;
            end
            OP_WT_TS: begin
              power_integral <= sat_add(power_integral, clamp_shift(prod, 48), w_neg ^ t_neg);
              op <= OP_WW;
            end
            OP_WW: begin
              pr <= prod[63:0];
              op <= OP_WW_TS;
            end
            OP_WW_TS: begin
              speed_sq_integral <= sat_add(speed_sq_integral, clamp_shift(prod, 48), 1'b0);
              op <= OP_T_TS;
            end
            OP_T_TS: begin
              torque_integral <= sat_add(torque_integral, clamp_shift(prod, 32), t_neg);
              op <= OP_TI_W;
            end
            OP_TI_W: begin
              pr <= clamp_shift(prod, 16);
              op <= OP_TIW_TS;
            end
            OP_TIW_TS: begin
              torque_int_speed_sum <= sat_add(torque_int_speed_sum, clamp_shift(prod, 32),
                                              torque_integral[ACC_WIDTH-1] ^ w_neg);
              op <= OP_RPM;
            end
            OP_RPM: begin
              rpm_mag <= 24'((prod[63:0] + 64'd16384) >> 15);
              op <= OP_RAD;
            end
            default: begin
              rad_mag <= 32'((prod[63:0] + 64'd32768) >> 16);
              invalid <= (speed_sq_integral == '0);
              div_sel <= 1'b0;
              state <= (speed_sq_integral == '0) ? ST_FINAL : ST_DSTART;
            end
          endcase
        end
        ST_DSTART: begin
          div_neg <= num_ext[63];
          cnt <= '0;
          quo <= '0;
          if ({15'd0, num_mag} >= {den, 15'd0}) begin
            div_sat <= 1'b1;
            state <= ST_DDONE;
          end else begin
            div_sat <= 1'b0;
            rem <= {15'd0, num_mag[63:15]};
            nb <= {num_mag[14:0], 16'd0};
            state <= ST_DRUN;
          end
        end
        ST_DRUN: begin
          rem <= div_bit ? 64'(rem_shift - {1'b0, den}) : rem_shift[63:0];
          quo <= {quo[29:0], div_bit};
          nb <= {nb[29:0], 1'b0};
          cnt <= cnt + 5'd1;
          if (cnt == 5'd30) state <= ST_DDONE;
        end
        ST_DDONE: begin
          if (div_sel) begin
            cur_inertia <= div_res;
            state <= ST_FINAL;
          end else begin
            cur_damping <= div_res;
            div_sel <= 1'b1;
            state <= ST_DSTART;
          end
        end
        ST_FINAL: begin
          if ({1'b0, sample_count} > period_limit) begin
            if (period_counter < midi_pkg::PERIOD_MAX) period_counter <= period_counter + 9'd1;
            held_damping <= cur_damping;
            held_inertia <= cur_inertia;
          end
          if (done_flag || (sample_count > finish_limit)) begin
            done_flag <= 1'b1;
            rpm_mag <= '0;
            rad_mag <= '0;
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid || !out_stall) begin
            out_data.speed_ref_rpm <= sine_val[15] && in_stall ? -$signed(rpm_mag)
                                                               : $signed(rpm_mag);
            out_data.speed_ref_rad <= sine_val[15] && in_stall ? -$signed(rad_mag)
                                                               : $signed(rad_mag);
            out_data.damping_est <= cur_damping;
            out_data.inertia_est <= cur_inertia;
            out_data.damping_held <= held_damping;
            out_data.inertia_held <= held_inertia;
            out_data.period_index <= period_counter;
            out_data.finished <= done_flag;
            out_data.divide_invalid <= invalid;
            out_valid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_period_range: assert property (@(posedge clk) disable iff (rst)
    period_counter != 9'd0 && period_counter <= midi_pkg::PERIOD_MAX)
    else $error("period counter out of range");

  a_speed_sq_nonneg: assert property (@(posedge clk) disable iff (rst)
    !speed_sq_integral[ACC_WIDTH-1])
    else $error("speed squared integral went negative");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_OUT)
    else $error("result raised outside the output state");

  a_finished_zero_ref: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.finished |-> out_data.speed_ref_rpm == '0
      && out_data.speed_ref_rad == '0)
    else $error("reference not zero after finishing");

endmodule

@@ tb/tb_motor_inertia_damping_identifier_core.sv @@
module tb_motor_inertia_damping_identifier_core;

  localparam longint unsigned ACC_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int CYCLE_LIMIT = 6000000;
  localparam int RANDOM_ITEMS = 1830;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  midi_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall;
  midi_pkg::out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [midi_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [midi_pkg::CFG_DATA_W-1:0] cfg_data;

  motor_inertia_damping_identifier_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Shadow copy of the identifier state.
  logic signed [15:0] sine_lut [256];
  logic [22:0] amp_rpm;
  logic [31:0] phase_inc;
  logic [23:0] period_len;
  logic [7:0] period_total;
  logic [31:0] step_time;
  logic [31:0] n_samples;
  logic [31:0] phase;
  logic [8:0] period_no;
  logic signed [63:0] pwr_int, wsq_int, trq_int, trq_w_int;
  logic signed [31:0] damp_now, inert_now, damp_latched, inert_latched;
  logic run_done;

  midi_pkg::out_item_t expected_q[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int sender_idle_pct = 9;
  int stall_pct = 47;
  int hold_go = 0;
  int hold_left = 0;
  int cycles = 0;

  typedef struct {
    logic func;
    logic signed [31:0] speed;
    logic signed [31:0] torque;
    logic typed;
    midi_pkg::out_item_t result;
  } stim_row_t;
  stim_row_t stim_table[$];

  function automatic void build_sine();
    logic [63:0] f, quad, w, x, x2, t, s, v;
    for (int k = 0; k < 256; k++) begin
      f = 64'(k) << 24;
      quad = f >> 30;
      w = f & 64'h3FFF_FFFF;
      if (quad[0]) w = midi_pkg::ONE_Q30 - w;
      x = (w * midi_pkg::HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      t = midi_pkg::ONE_Q30 - x2 / 72;
      t = midi_pkg::ONE_Q30 - ((x2 * t) >> 30) / 42;
      t = midi_pkg::ONE_Q30 - ((x2 * t) >> 30) / 20;
      t = midi_pkg::ONE_Q30 - ((x2 * t) >> 30) / 6;
      s = (x * t) >> 30;
      v = (s * 32767 + (64'd1 << 29)) >> 30;
      if (v > 32767) v = 32767;
      sine_lut[k] = (quad >= 2) ? -16'(v) : 16'(v);
    end
  endfunction

  function automatic logic [63:0] scaled_product(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> sh;
    return (p > ACC_MAX) ? ACC_MAX : p[63:0];
  endfunction

  function automatic logic signed [63:0] sat_accumulate(logic signed [63:0] acc,
                                                         logic [63:0] mag, logic neg);
    logic signed [64:0] sum;
    sum = neg ? 65'(acc) - 65'(mag) : 65'(acc) + 65'(mag);
    if (sum > 65'sd9223372036854775807) return 64'h7FFF_FFFF_FFFF_FFFF;
    if (sum < -65'sd9223372036854775808) return 64'h8000_0000_0000_0000;
    return sum[63:0];
  endfunction

  function automatic logic signed [31:0] ratio_q16(logic signed [63:0] num,
                                                     logic signed [63:0] den);
    logic [127:0] q;
    logic [63:0] n;
    n = num[63] ? -num : num;
    q = ({64'd0, n} << 16) / {64'd0, den};
    if (q >= 128'h8000_0000) return num[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    return num[63] ? -q[31:0] : q[31:0];
  endfunction

  function automatic void clear_run();
    n_samples = 0;
    phase = 0;
    period_no = 1;
    pwr_int = 0;
    wsq_int = 0;
    trq_int = 0;
    trq_w_int = 0;
    run_done = 0;
    damp_now = 0;
    inert_now = 0;
  endfunction

  function automatic midi_pkg::out_item_t identify_sample(midi_pkg::in_item_t it);
    midi_pkg::out_item_t r;
    logic [63:0] wm, tm, rpm_mag, rad_mag, m, smag;
    logic ref_neg, invalid;
    logic signed [15:0] sv;
    rpm_mag = 0;
    rad_mag = 0;
    ref_neg = 0;
    if (!it.func) begin
      clear_run();
      invalid = 1;
    end else begin
      wm = it.speed[31] ? 64'(-65'(it.speed)) : 64'(it.speed);
      tm = it.torque[31] ? 64'(-65'(it.torque)) : 64'(it.torque);
      if (n_samples != 32'hFFFF_FFFF) n_samples++;
      phase += phase_inc;
      sv = sine_lut[phase[31:24]];
      ref_neg = sv < 0;
      smag = ref_neg ? 64'(-sv) : 64'(sv);
      rpm_mag = (64'(amp_rpm) * smag + 16384) >> 15;
      rad_mag = (rpm_mag * midi_pkg::RPM_TO_RAD_Q16 + 32768) >> 16;
      pwr_int = sat_accumulate(pwr_int, scaled_product(wm * tm, step_time, 48),
                               it.speed[31] != it.torque[31]);
      wsq_int = sat_accumulate(wsq_int, scaled_product(wm * wm, step_time, 48), 1'b0);
      trq_int = sat_accumulate(trq_int, scaled_product(tm, step_time, 32), it.torque[31]);
      m = scaled_product(trq_int[63] ? -trq_int : trq_int, wm, 16);
      trq_w_int = sat_accumulate(trq_w_int, scaled_product(m, step_time, 32),
                                 trq_int[63] != it.speed[31]);
      invalid = (wsq_int <= 0);
      if (!invalid) begin
        damp_now = ratio_q16(pwr_int, wsq_int);
        inert_now = ratio_q16(trq_w_int, wsq_int);
      end
      if (64'(n_samples) > 64'(period_len) * 64'(period_no)) begin
        if (period_no < midi_pkg::PERIOD_MAX) period_no++;
        damp_latched = damp_now;
        inert_latched = inert_now;
      end
      if (64'(n_samples) > 64'(period_total) * 64'(period_len)) run_done = 1;
      if (run_done) begin
        rpm_mag = 0;
        rad_mag = 0;
      end
    end
    r.speed_ref_rpm = ref_neg ? -24'(rpm_mag) : 24'(rpm_mag);
    r.speed_ref_rad = ref_neg ? -32'(rad_mag) : 32'(rad_mag);
    r.damping_est = damp_now;
    r.inertia_est = inert_now;
    r.damping_held = damp_latched;
    r.inertia_held = inert_latched;
    r.period_index = period_no;
    r.finished = run_done;
    r.divide_invalid = invalid;
    return r;
  endfunction

  task automatic compare_result(midi_pkg::out_item_t got, midi_pkg::out_item_t exp);
    if (got.speed_ref_rpm !== exp.speed_ref_rpm) begin
      $error("speed_ref_rpm expected %0d actual %0d", exp.speed_ref_rpm, got.speed_ref_rpm);
      errors++;
    end
    if (got.speed_ref_rad !== exp.speed_ref_rad) begin
      $error("speed_ref_rad expected %0d actual %0d", exp.speed_ref_rad, got.speed_ref_rad);
      errors++;
    end
    if (got.damping_est !== exp.damping_est) begin
      $error("damping_est expected %0d actual %0d", exp.damping_est, got.damping_est);
      errors++;
    end
    if (got.inertia_est !== exp.inertia_est) begin
      $error("inertia_est expected %0d actual %0d", exp.inertia_est, got.inertia_est);
      errors++;
    end
    if (got.damping_held !== exp.damping_held) begin
      $error("damping_held expected %0d actual %0d", exp.damping_held, got.damping_held);
      errors++;
    end
    if (got.inertia_held !== exp.inertia_held) begin
      $error("inertia_held expected %0d actual %0d", exp.inertia_held, got.inertia_held);
      errors++;
    end
    if (got.period_index !== exp.period_index) begin
      $error("period_index expected %0d actual %0d", exp.period_index, got.period_index);
      errors++;
    end
    if (got.finished !== exp.finished) begin
      $error("finished expected %0d actual %0d", exp.finished, got.finished);
      errors++;
    end
    if (got.divide_invalid !== exp.divide_invalid) begin
      $error("divide_invalid expected %0d actual %0d", exp.divide_invalid,
             got.divide_invalid);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          $error("result arrived with no item outstanding");
          errors++;
        end else begin
          compare_result(out_data, expected_q.pop_front());
        end
      end
      if (hold_go != 0) begin
        hold_left = 3000;
        hold_go = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_motor_inertia_damping_identifier_core: errors");
      $finish;
    end
  end

  task automatic send_item(midi_pkg::in_item_t it, logic typed,
                           midi_pkg::out_item_t typed_result);
    midi_pkg::out_item_t r;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    r = identify_sample(it);
    expected_q.push_back(typed ? typed_result : r);
    items_sent++;
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_regs(logic [22:0] a, logic [31:0] p, logic [23:0] s,
                            logic [7:0] n, logic [31:0] t);
    logic [midi_pkg::CFG_IDX_W-1:0] idx [5];
    logic [31:0] val [5];
    idx = '{midi_pkg::CFG_AMPLITUDE, midi_pkg::CFG_PHASE_STEP,
            midi_pkg::CFG_SAMPLES_PER_PERIOD, midi_pkg::CFG_NUM_PERIODS,
            midi_pkg::CFG_SAMPLE_TIME};
    val = '{32'(a), p, 32'(s), 32'(n), t};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    amp_rpm = a;
    phase_inc = p;
    period_len = s;
    period_total = n;
    step_time = t;
  endtask

  function automatic logic signed [31:0] rand_operand();
    case ($urandom_range(9))
      0: return 0;
      1, 2, 3: return $urandom();
      default: return $signed(32'($urandom_range(2097151))) - 32'sd1048576;
    endcase
  endfunction

  function automatic void add_row(logic f, logic signed [31:0] w, logic signed [31:0] t,
                                  logic typed, midi_pkg::out_item_t r);
    stim_row_t row;
    row.func = f;
    row.speed = w;
    row.torque = t;
    row.typed = typed;
    row.result = r;
    stim_table.push_back(row);
  endfunction

  initial begin
    midi_pkg::out_item_t cleared, none;
    midi_pkg::in_item_t it;
    int rnd_done;
    int ph;
    int ph_items;
    cleared = '{speed_ref_rpm: 0, speed_ref_rad: 0, damping_est: 0, inertia_est: 0,
                damping_held: 0, inertia_held: 0, period_index: 9'd1, finished: 0,
                divide_invalid: 1};
    none = '0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = midi_pkg::CFG_AMPLITUDE;
    cfg_data = '0;
    build_sine();
    amp_rpm = midi_pkg::RST_AMPLITUDE;
    phase_inc = midi_pkg::RST_PHASE_STEP;
    period_len = midi_pkg::RST_SAMPLES_PER_PERIOD;
    period_total = midi_pkg::RST_NUM_PERIODS;
    step_time = midi_pkg::RST_SAMPLE_TIME;
    clear_run();
    damp_latched = 0;
    inert_latched = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_row(0, 0, 0, 1, cleared);
    add_row(1, 0, 0, 0, none);
    add_row(1, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, none);
    add_row(1, 32'sh80000000, 32'sh80000000, 0, none);
    add_row(1, 32'sh80000000, 32'sh7FFFFFFF, 0, none);
    add_row(1, 32'sh7FFFFFFF, 32'sh80000000, 0, none);
    add_row(0, 0, 0, 0, none);
    add_row(1, 1, 32'sh7FFFFFFF, 0, none);
    add_row(1, 1, 32'sh7FFFFFFF, 0, none);
    add_row(1, -1, 32'sh80000000, 0, none);
    add_row(1, 32'sh00010000, 32'sh00020000, 0, none);
    add_row(1, -32'sh00030000, 32'sh00008000, 0, none);
    add_row(0, 32'sh7FFFFFFF, -1, 0, none);
    add_row(1, 32'sh00001000, -32'sh7FFFFFFF, 0, none);
    add_row(1, 32'sh55555555, 32'shAAAAAAAA, 0, none);
    foreach (stim_table[i]) begin
      it.func = stim_table[i].func;
      it.speed = stim_table[i].speed;
      it.torque = stim_table[i].torque;
      send_item(it, stim_table[i].typed, stim_table[i].result);
    end

    rnd_done = 0;
    ph = 0;
    while (rnd_done < RANDOM_ITEMS) begin
      wait_drained();
      case (ph % 6)
        0: write_regs(23'h7FFFFF, 32'hFFFFFFFF, 24'd1, 8'd1, 32'hFFFFFFFF);
        1: write_regs(23'd0, 32'd0, 24'hFFFFFF, 8'd255, 32'd1);
        2: write_regs(midi_pkg::RST_AMPLITUDE, midi_pkg::RST_PHASE_STEP,
                      midi_pkg::RST_SAMPLES_PER_PERIOD, midi_pkg::RST_NUM_PERIODS,
                      midi_pkg::RST_SAMPLE_TIME);
        default: write_regs(23'($urandom()), $urandom(), 24'($urandom_range(8, 1)),
                            8'($urandom_range(6, 1)), $urandom());
      endcase
      if (ph == 4) hold_go = 1;
      ph_items = (ph % 6 == 2) ? 200 : $urandom_range(90, 30);
      for (int k = 0; k < ph_items && rnd_done < RANDOM_ITEMS; k++) begin
        if (rnd_done < 600) begin
          sender_idle_pct = 9;
          stall_pct = 47;
        end else if (rnd_done < 1200) begin
          sender_idle_pct = 47;
          stall_pct = 9;
        end else begin
          sender_idle_pct = 0;
          stall_pct = 0;
        end
        it.func = (k == 0) ? 1'b0 : ($urandom_range(99) >= 3);
        it.speed = rand_operand();
        it.torque = rand_operand();
        send_item(it, 1'b0, none);
        rnd_done++;
      end
      ph++;
    end

    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    $display("Sent %0d items over %0d register settings, checked %0d results.",
             items_sent, ph + 1, results_seen);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb_motor_inertia_damping_identifier_core: clean");
    end else begin
      $display("tb_motor_inertia_damping_identifier_core: errors");
    end
    $finish;
  end

endmodule
